FILE: rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the buffer tag cache
// command and status codes, request record passed from front to back
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int DEFAULT_BUFFER_COUNT = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_GET     = 2'd0,
      CMD_DIRTY   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_MISS     = 3'd1,
      ST_NOFREE   = 3'd2,
      ST_UNDERRUN = 3'd3,
      ST_DONE     = 3'd4,
      ST_OVERFLOW = 3'd5
   } status_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  table_id;
      logic [31:0] block_number;
      logic [3:0]  buffer_index;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  granted_buffer;
      logic        writeback_needed;
      logic [7:0]  writeback_table;
      logic [31:0] writeback_block;
      logic        fill_needed;
   } rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_UPDATE,
      BK_OUT
   } back_state_type;

endpackage

FILE: rtl/block_buffer_cache_lru.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_lru: fully associative buffer tag cache with lru
// get, mark dirty and release commands, one result transfer per request
// ----------------------------------------------------------------------------
// each request passes through the back end states in order (pop, tag compare
// and victim scan, state update, result), and the result is held until
// rsp_tready; the two-entry queue keeps taking requests meanwhile until full. the
// sequencer in the back end handles one request at a time since each one
// depends on the reference counts and recency left by the previous one.
// reset clears every entry directly, with no clearing pass.
module block_buffer_cache_lru #(
   parameter int BUFFER_COUNT = bbc_pkg::DEFAULT_BUFFER_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[1:0], table_id[9:2], block_number[41:10], buffer_index[45:42]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], granted_buffer[6:3], writeback_needed[7],
   // writeback_table[15:8], writeback_block[47:16], fill_needed[48]
   output logic [55:0] rsp_tdata
);
   import bbc_pkg::*;

   logic    q_valid, q_pop;
   req_type q_req;
   rsp_type rsp;

   bbc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_req      (q_req),
      .q_pop      (q_pop)
   );

   bbc_back #(.BUFFER_COUNT(BUFFER_COUNT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_req     (q_req),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp)
   );

   // pack the result fields, lowest first
   assign rsp_tdata = {7'd0, rsp.fill_needed, rsp.writeback_block, rsp.writeback_table,
                       rsp.writeback_needed, rsp.granted_buffer, rsp.status};

endmodule

FILE: rtl/bbc_front.sv
// ----------------------------------------------------------------------------
// bbc_front: request intake and queue
// accepts stream transfers, decodes the command and queues the request
// ----------------------------------------------------------------------------
module bbc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [47:0]       req_tdata,
   output logic              q_valid,
   output bbc_pkg::req_type  q_req,
   input  logic              q_pop
);
   import bbc_pkg::*;

   req_type    slot_ff [QUEUE_DEPTH];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push;
   req_type    incoming;

   always_comb begin
      incoming.cmd          = cmd_type'(req_tdata[1:0]);
      incoming.table_id     = req_tdata[9:2];
      incoming.block_number = req_tdata[41:10];
      incoming.buffer_index = req_tdata[45:42];
   end

   assign req_tready = (count_ff != 2'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_req      = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(q_pop);
      rd_in    = rd_ff ^ q_pop;
      wr_in    = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= incoming;
      end
   end

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH)) else $error("queue count out of range");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count missed a push");
`endif

endmodule

FILE: rtl/bbc_back.sv
// ----------------------------------------------------------------------------
// bbc_back: tag store and command execution
// scans entries for hit and victim, updates state, holds the result
// ----------------------------------------------------------------------------
module bbc_back #(
   parameter int BUFFER_COUNT = bbc_pkg::DEFAULT_BUFFER_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  bbc_pkg::req_type  q_req,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bbc_pkg::rsp_type  rsp_data
);
   import bbc_pkg::*;

   localparam int IW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;

   logic          assigned_ff [BUFFER_COUNT];
   logic [7:0]    tab_ff      [BUFFER_COUNT];
   logic [31:0]   blk_ff      [BUFFER_COUNT];
   logic [7:0]    refs_ff     [BUFFER_COUNT];
   logic          dval_ff     [BUFFER_COUNT];
   logic          dirty_ff    [BUFFER_COUNT];
   logic [IW-1:0] rank_ff     [BUFFER_COUNT];

   back_state_type state_ff, state_in;
   req_type        cur_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           found_ff, have_ff;
   logic [IW-1:0]  hit_ff, vic_ff;

   logic           found_c, have_c, idx_ok;
   logic [IW-1:0]  hit_c, vic_c, idx;
   logic [IW-1:0]  best_c;
   logic [7:0]     idx_full;

   assign idx_full = {4'd0, cur_ff.buffer_index};
   assign idx_ok   = (32'(idx_full) < BUFFER_COUNT);
   assign idx      = idx_full[IW-1:0];

   // parallel tag compare and oldest free entry search
   always_comb begin
      found_c = 1'b0;
      hit_c   = '0;
      have_c  = 1'b0;
      vic_c   = '0;
      best_c  = '0;
      for (int i = BUFFER_COUNT - 1; i >= 0; i--) begin
         if (assigned_ff[i] && tab_ff[i] == cur_ff.table_id &&
             blk_ff[i] == cur_ff.block_number) begin
            found_c = 1'b1;
            hit_c   = IW'(i);
         end
      end
      for (int i = 0; i < BUFFER_COUNT; i++) begin
         if (refs_ff[i] == 8'd0 && (!have_c || rank_ff[i] > best_c)) begin
            have_c = 1'b1;
            best_c = rank_ff[i];
            vic_c  = IW'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      rsp_in   = rsp_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = BK_SCAN;
            end
         end
         BK_SCAN:   state_in = BK_UPDATE;
         BK_UPDATE: begin
            rsp_in        = '0;
            rsp_in.status = ST_DONE;
            unique case (cur_ff.cmd)
               CMD_GET: begin
                  if (found_ff) begin
                     rsp_in.granted_buffer = 4'(hit_ff);
                     if (refs_ff[hit_ff] == 8'hFF) begin
                        rsp_in.status = ST_OVERFLOW;
                     end else begin
                        rsp_in.status      = ST_HIT;
                        rsp_in.fill_needed = !dval_ff[hit_ff];
                     end
                  end else if (!have_ff) begin
                     rsp_in.status = ST_NOFREE;
                  end else begin
                     rsp_in.status         = ST_MISS;
                     rsp_in.granted_buffer = 4'(vic_ff);
                     rsp_in.fill_needed    = 1'b1;
                     if (assigned_ff[vic_ff] && dirty_ff[vic_ff]) begin
                        rsp_in.writeback_needed = 1'b1;
                        rsp_in.writeback_table  = tab_ff[vic_ff];
                        rsp_in.writeback_block  = blk_ff[vic_ff];
                     end
                  end
               end
               CMD_RELEASE: begin
                  if (idx_ok && refs_ff[idx] == 8'd0) begin
                     rsp_in.status = ST_UNDERRUN;
                  end
               end
               default: rsp_in.status = ST_DONE;
            endcase
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (rsp_ready) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         for (int i = 0; i < BUFFER_COUNT; i++) begin
            assigned_ff[i] <= 1'b0;
            tab_ff[i]      <= 8'd0;
            blk_ff[i]      <= 32'd0;
            refs_ff[i]     <= 8'd0;
            dval_ff[i]     <= 1'b0;
            dirty_ff[i]    <= 1'b0;
            rank_ff[i]     <= IW'(BUFFER_COUNT - 1 - i);
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_UPDATE) begin
            unique case (cur_ff.cmd)
               CMD_GET: begin
                  if (found_ff) begin
                     if (refs_ff[hit_ff] != 8'hFF) begin
                        refs_ff[hit_ff] <= refs_ff[hit_ff] + 8'd1;
                        dval_ff[hit_ff] <= 1'b1;
                     end
                  end else if (have_ff) begin
                     assigned_ff[vic_ff] <= 1'b1;
                     tab_ff[vic_ff]      <= cur_ff.table_id;
                     blk_ff[vic_ff]      <= cur_ff.block_number;
                     dirty_ff[vic_ff]    <= 1'b0;
                     refs_ff[vic_ff]     <= 8'd1;
                     dval_ff[vic_ff]     <= 1'b1;
                  end
               end
               CMD_DIRTY: begin
                  if (idx_ok && assigned_ff[idx]) begin
                     dirty_ff[idx] <= 1'b1;
                  end
               end
               CMD_RELEASE: begin
                  if (idx_ok && refs_ff[idx] != 8'd0) begin
                     refs_ff[idx] <= refs_ff[idx] - 8'd1;
                     if (refs_ff[idx] == 8'd1) begin
                        for (int i = 0; i < BUFFER_COUNT; i++) begin
                           if (rank_ff[i] < rank_ff[idx]) begin
                              rank_ff[i] <= rank_ff[i] + IW'(1);
                           end
                        end
                        rank_ff[idx] <= '0;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
      if (q_pop) begin
         cur_ff <= q_req;
      end
      if (state_ff == BK_SCAN) begin
         found_ff <= found_c;
         hit_ff   <= hit_c;
         have_ff  <= have_c;
         vic_ff   <= vic_c;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = (state_ff == BK_OUT);
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == BK_IDLE) else $error("pop outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_update_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_UPDATE |=> rsp_valid) else $error("result not shown");
`endif

endmodule

FILE: test/tb_block_buffer_cache_lru.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_buffer_cache_lru: self-checking bench of the buffer tag cache
// a behavioral copy of the cache predicts every result transfer; directed
// corner cases come first, then random get/dirty/release/unknown traffic with idling
// ----------------------------------------------------------------------------
module tb_block_buffer_cache_lru;
   import bbc_pkg::*;

   localparam int NBUF = 16;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // command[1:0], table_id[9:2], block_number[41:10], buffer_index[45:42]
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // status[2:0], granted_buffer[6:3], writeback_needed[7],
   // writeback_table[15:8], writeback_block[47:16], fill_needed[48]
   logic [55:0] rsp_tdata;

   typedef struct {
      status_type  status;
      logic [3:0]  granted;
      logic        wb;
      logic [7:0]  wb_table;
      logic [31:0] wb_block;
      logic        fill;
   } answer_type;

   // model of the cache contents
   logic        m_assigned [NBUF];
   logic [7:0]  m_table    [NBUF];
   logic [31:0] m_block    [NBUF];
   logic [7:0]  m_refs     [NBUF];
   logic        m_valid    [NBUF];
   logic        m_dirty    [NBUF];
   int          m_rank     [NBUF];

   answer_type pending_answers[$];
   int      errors = 0;
   int      cycles = 0;
   int      sent = 0;
   int      checked = 0;
   int      tx_idle = 0;   // percent of cycles the sender idles
   int      rx_idle = 0;   // percent of cycles the receiver stalls

   block_buffer_cache_lru u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic cache_clear();
      for (int i = 0; i < NBUF; i++) begin
         m_assigned[i] = 0; m_table[i] = 0; m_block[i] = 0;
         m_refs[i] = 0; m_valid[i] = 0; m_dirty[i] = 0;
         m_rank[i] = NBUF - 1 - i;
      end
   endtask

   // work out the answer to one request and update the model
   function automatic answer_type cache_access(cmd_type cmd, logic [7:0] tab,
                                               logic [31:0] blk, logic [3:0] idx);
      answer_type a;
      int      e;
      int      best;
      int      r;
      bit      found;
      a = '{ST_DONE, 0, 0, 0, 0, 0};
      found = 0;
      e = 0;
      case (cmd)
         CMD_GET: begin
            for (int i = 0; i < NBUF; i++)
               if (!found && m_assigned[i] && m_table[i] == tab && m_block[i] == blk) begin
                  found = 1;
                  e = i;
               end
            if (found) begin
               a.granted = 4'(e);
               if (m_refs[e] == 8'hFF) begin
                  a.status = ST_OVERFLOW;
               end else begin
                  m_refs[e]++;
                  a.status = ST_HIT;
                  if (!m_valid[e]) begin
                     a.fill = 1;
                     m_valid[e] = 1;
                  end
               end
            end else begin
               // victim: least recent unreferenced entry
               best = -1;
               for (int i = 0; i < NBUF; i++)
                  if (m_refs[i] == 0 && m_rank[i] > best) begin
                     best = m_rank[i];
                     e = i;
                  end
               if (best < 0) begin
                  a.status = ST_NOFREE;
               end else begin
                  if (m_assigned[e] && m_dirty[e]) begin
                     a.wb = 1;
                     a.wb_table = m_table[e];
                     a.wb_block = m_block[e];
                  end
                  m_assigned[e] = 1; m_table[e] = tab; m_block[e] = blk;
                  m_dirty[e] = 0; m_refs[e] = 1; m_valid[e] = 1;
                  a.fill = 1;
                  a.status = ST_MISS;
                  a.granted = 4'(e);
               end
            end
         end
         CMD_DIRTY: begin
            if (m_assigned[idx]) m_dirty[idx] = 1;
         end
         CMD_RELEASE: begin
            if (m_refs[idx] == 0) begin
               a.status = ST_UNDERRUN;
            end else begin
               m_refs[idx]--;
               if (m_refs[idx] == 0) begin
                  r = m_rank[idx];
                  for (int i = 0; i < NBUF; i++)
                     if (m_rank[i] < r) m_rank[i]++;
                  m_rank[idx] = 0;
               end
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   // send one request transfer and queue its expected answer
   task automatic send_request(cmd_type cmd, logic [7:0] tab, logic [31:0] blk,
                               logic [3:0] idx);
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tdata <= {2'b00, idx, blk, tab, cmd};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_answers.push_back(cache_access(cmd, tab, blk, idx));
      sent++;
      @(negedge clock);
   endtask

   // receiver: random stalls, compare at the rising edge
   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(99) >= rx_idle);
   end

   always @(posedge clock) begin
      answer_type x;
      status_type got_status;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = status_type'(rsp_tdata[2:0]);
         if (pending_answers.size() == 0) begin
            $error("unexpected result transfer %h", rsp_tdata);
            errors++;
         end else begin
            x = pending_answers.pop_front();
            checked++;
            if (got_status !== x.status) begin
               $error("status exp %0d got %0d", x.status, rsp_tdata[2:0]); errors++;
            end
            if (rsp_tdata[6:3] !== x.granted) begin
               $error("granted_buffer exp %0d got %0d", x.granted, rsp_tdata[6:3]);
               errors++;
            end
            if (rsp_tdata[7] !== x.wb) begin
               $error("writeback_needed exp %0d got %0d", x.wb, rsp_tdata[7]); errors++;
            end
            if (rsp_tdata[15:8] !== x.wb_table) begin
               $error("writeback_table exp %h got %h", x.wb_table, rsp_tdata[15:8]);
               errors++;
            end
            if (rsp_tdata[47:16] !== x.wb_block) begin
               $error("writeback_block exp %h got %h", x.wb_block, rsp_tdata[47:16]);
               errors++;
            end
            if (rsp_tdata[48] !== x.fill) begin
               $error("fill_needed exp %0d got %0d", x.fill, rsp_tdata[48]); errors++;
            end
         end
      end
   end

   // corners: extremes of tags, all commands, underflow, dirty on an unassigned
   // entry, no free buffer, unknown command
   task automatic test_directed();
      send_request(CMD_RELEASE, 0, 0, 4'd0);              // underflow at reset
      send_request(CMD_DIRTY, 0, 0, 4'd15);               // dirty on unassigned
      send_request(CMD_NONE, 8'hFF, 32'hFFFFFFFF, 4'hF);  // unknown command
      send_request(CMD_GET, 0, 0, 0);                     // miss
      send_request(CMD_GET, 0, 0, 0);                     // hit
      send_request(CMD_GET, 8'hFF, 32'hFFFFFFFF, 0);      // miss, top values
      send_request(CMD_DIRTY, 0, 0, 4'd15);
      send_request(CMD_RELEASE, 0, 0, 4'd15);
      send_request(CMD_RELEASE, 0, 0, 4'd15);
      send_request(CMD_RELEASE, 0, 0, 4'd15);             // underflow
      for (int i = 0; i < 15; i++) send_request(CMD_GET, 8'd1, i, 0);
      send_request(CMD_GET, 8'd2, 32'h5A5A5A5A, 0);       // no free buffer
      send_request(CMD_GET, 8'd3, 32'h1, 0);              // no free buffer
   endtask

   // pump one entry up to the reference ceiling and beyond
   task automatic test_overflow();
      for (int i = 0; i < 16; i++) send_request(CMD_RELEASE, 0, 0, 4'(i));
      for (int i = 0; i < 256; i++) send_request(CMD_GET, 8'h77, 32'hCAFE, 0);
      send_request(CMD_GET, 8'h77, 32'hCAFE, 0);          // refused at ceiling
   endtask

   // random traffic over a small tag pool so hits, victims and frees mix
   task automatic test_random(int count);
      cmd_type     c;
      logic [7:0]  tab;
      logic [31:0] blk;
      int          k;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(99);
         c = (k < 45) ? CMD_GET : (k < 60) ? CMD_DIRTY : (k < 97) ? CMD_RELEASE : CMD_NONE;
         if ($urandom_range(9) == 0) begin
            tab = 8'($urandom);
            blk = $urandom;
         end else begin
            tab = 8'($urandom_range(3));
            blk = $urandom_range(11);
         end
         send_request(c, tab, blk, 4'($urandom));
      end
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 0;
      while (pending_answers.size() != 0) @(posedge clock);
      while (guard < 20) begin
         @(posedge clock);
         guard++;
      end
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      cache_clear();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_overflow();
      tx_idle = 10; rx_idle = 70;
      test_random(450);
      tx_idle = 70; rx_idle = 10;
      test_random(450);
      tx_idle = 0; rx_idle = 0;
      test_random(550);
      drain();
      $display("covered %0d requests, %0d results checked: hits, misses, writebacks,",
               sent, checked);
      $display("no-free, underflow and reference ceiling cases under three idle mixes");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
